// ===== rtl/oht_pkg.sv =====
package oht_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_GOAL_TEMP         = 3'd0,
        REG_STOP_BAND_ABOVE   = 3'd1,
        REG_START_BAND_BELOW  = 3'd2,
        REG_EARLY_STOP_ABOVE  = 3'd3,
        REG_EARLY_START_ABOVE = 3'd4,
        REG_MIN_ON_SECONDS    = 3'd5,
        REG_MIN_OFF_SECONDS   = 3'd6
    } t_reg_index;

    localparam int unsigned TEMP_W = 8;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned WARM_W = 16;
    localparam int unsigned HOLD_W = 4;
    localparam int unsigned LVL_W  = 2;
    localparam int unsigned CMP_W  = 10;

    // Reset values of the configuration registers.
    localparam logic [TEMP_W-1:0] RST_GOAL_TEMP         = 8'd128;
    localparam logic [TEMP_W-1:0] RST_STOP_BAND_ABOVE   = 8'd22;
    localparam logic [TEMP_W-1:0] RST_START_BAND_BELOW  = 8'd0;
    localparam logic [TEMP_W-1:0] RST_EARLY_STOP_ABOVE  = 8'd17;
    localparam logic [TEMP_W-1:0] RST_EARLY_START_ABOVE = 8'd3;
    localparam logic [CNT_W-1:0]  RST_MIN_ON_SECONDS    = 8'd80;
    localparam logic [CNT_W-1:0]  RST_MIN_OFF_SECONDS   = 8'd30;

    // Warm-up thresholds.
    localparam logic [TEMP_W-1:0] WARM_EXIT_DIFF  = 8'd35;
    localparam logic [WARM_W-1:0] WARM_EARLY_SECS = 16'd120;
    localparam logic [WARM_W-1:0] WARM_MID_SECS   = 16'd240;
    localparam logic [TEMP_W-1:0] WARM_COLD_TEMP  = 8'd80;
    localparam logic [TEMP_W-1:0] WARM_MID_TEMP   = 8'd100;
    localparam logic [CNT_W-1:0]  WARM_LIMIT_COLD = 8'd11;
    localparam logic [CNT_W-1:0]  WARM_LIMIT_MID  = 8'd16;
    localparam logic [CNT_W-1:0]  WARM_LIMIT_HOT  = 8'd22;

    // Regulation thresholds.
    localparam logic [CNT_W-1:0]  FORCED_RESTART_SECS = 8'd60;
    localparam logic [CNT_W-1:0]  DUTY_LOW_SECS       = 8'd2;
    localparam logic [CNT_W-1:0]  DUTY_PERIOD_LAST    = 8'd12;
    localparam logic [HOLD_W-1:0] HOLD_OFF_SECS       = 4'd10;

    localparam logic [LVL_W-1:0]  LEVEL_OFF  = 2'd0;
    localparam logic [LVL_W-1:0]  LEVEL_FULL = 2'd3;

endpackage

// ===== rtl/oven_heater_thermostat.sv =====
// Oven heater thermostat. Each transfer on the input channel carries one
// temperature reading (higher is hotter) and a flag marking a one-second tick;
// each produces exactly one transfer on the output channel with the heater
// level (0 off to 3 full), the heating flag and the phase after that reading.
// After reset the block passes through an init step, then warms up at full
// level until the reading comes closer than 35 counts to the goal, then
// regulates with a hysteresis thermostat: hard stop and start bands, early
// stop and start bands that apply only after the minimum on and off times, a
// forced restart after 60 s off and a 13-second duty cycle whose first three
// seconds give level 0. For ten seconds after regulation starts the level is
// held at 0. The block is a two-register pipeline: a reading is captured in an
// input register, and once the result register can take it, all the
// thermostat arithmetic (a handful of 10-bit compares and saturating counter
// updates) runs in one pass into the result register and the state registers.
// It takes one reading every clock cycle while the output side keeps taking
// results, and each result is offered on the output from the result register.
// Configuration registers are written through their own channel, which is
// always ready, and should only be written while no reading is in flight.
module oven_heater_thermostat (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // reading channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_now_temp,
    input  logic       i_second_tick,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_heat_level,
    output logic       o_heater_on,
    output logic [1:0] o_phase,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_INIT  = 2'd0,
        PH_WARM  = 2'd1,
        PH_REGUL = 2'd2
    } t_phase;

    localparam int unsigned TW = oht_pkg::TEMP_W;
    localparam int unsigned CW = oht_pkg::CNT_W;
    localparam int unsigned WW = oht_pkg::WARM_W;
    localparam int unsigned HW = oht_pkg::HOLD_W;
    localparam int unsigned LW = oht_pkg::LVL_W;
    localparam int unsigned SW = oht_pkg::CMP_W;

    // Configuration registers.
    logic [TW-1:0] r_goal_temp, r_stop_band_above, r_start_band_below;
    logic [TW-1:0] r_early_stop_above, r_early_start_above;
    logic [CW-1:0] r_min_on_seconds, r_min_off_seconds;

    // Input register.
    logic          r_in_valid;
    logic [TW-1:0] r_now_temp;
    logic          r_tick;

    // Thermostat state.
    t_phase        r_phase, n_phase;
    logic          r_flag, n_flag;
    logic [CW-1:0] r_on_secs, n_on_secs;
    logic [CW-1:0] r_off_secs, n_off_secs;
    logic [CW-1:0] r_cycle_secs, n_cycle_secs;
    logic [WW-1:0] r_warm_secs, n_warm_secs;
    logic [HW-1:0] r_hold_secs, n_hold_secs;
    logic [LW-1:0] r_level_hold, n_level;

    // Result register.
    logic          r_out_valid;
    logic [LW-1:0] r_out_level;
    logic          r_out_flag;
    logic [1:0]    r_out_phase;

    logic advance;
    logic in_take;

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign in_take     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign o_valid      = r_out_valid;
    assign o_heat_level = r_out_level;
    assign o_heater_on  = r_out_flag;
    assign o_phase      = r_out_phase;

    // Signed views for the band compares; goal minus a band may go negative
    // and goal plus a band may exceed 255, and neither may wrap.
    logic signed [SW-1:0] s_now, s_goal;
    logic signed [SW-1:0] s_stop_lim, s_start_lim, s_early_start_lim, s_early_stop_lim;

    assign s_now             = signed'({2'b00, r_now_temp});
    assign s_goal            = signed'({2'b00, r_goal_temp});
    assign s_stop_lim        = s_goal + signed'({2'b00, r_stop_band_above});
    assign s_start_lim       = s_goal - signed'({2'b00, r_start_band_below});
    assign s_early_start_lim = s_goal + signed'({2'b00, r_early_start_above});
    assign s_early_stop_lim  = s_goal + signed'({2'b00, r_early_stop_above});

    logic          near_goal;
    logic [TW:0]   goal_diff;
    logic [WW-1:0] warm_inc;
    logic [CW-1:0] cycle_inc, warm_limit, cycle_wrap;
    logic          reg_flag;

    assign goal_diff = {1'b0, r_goal_temp} - {1'b0, r_now_temp};
    // goal_diff[TW] set means the reading is above the goal.
    assign near_goal = goal_diff[TW] || (goal_diff[TW-1:0] < oht_pkg::WARM_EXIT_DIFF);

    always_comb begin
        // Warm-up counters, saturating.
        warm_inc  = r_warm_secs;
        cycle_inc = r_cycle_secs;
        if (r_tick) begin
            if (r_warm_secs != {WW{1'b1}}) begin
                warm_inc = r_warm_secs + WW'(1);
            end
            if (r_cycle_secs != {CW{1'b1}}) begin
                cycle_inc = r_cycle_secs + CW'(1);
            end
        end
        if (warm_inc < oht_pkg::WARM_EARLY_SECS && r_now_temp < oht_pkg::WARM_COLD_TEMP) begin
            warm_limit = oht_pkg::WARM_LIMIT_COLD;
        end else if (warm_inc < oht_pkg::WARM_MID_SECS
                     && r_now_temp < oht_pkg::WARM_MID_TEMP) begin
            warm_limit = oht_pkg::WARM_LIMIT_MID;
        end else begin
            warm_limit = oht_pkg::WARM_LIMIT_HOT;
        end

        // Thermostat decision from the hard and early bands.
        if (s_now > s_stop_lim) begin
            reg_flag = 1'b0;
        end else if (s_now <= s_start_lim) begin
            reg_flag = 1'b1;
        end else if (!r_flag) begin
            reg_flag = (r_off_secs > r_min_off_seconds) && (s_now <= s_early_start_lim);
        end else begin
            reg_flag = !((r_on_secs > r_min_on_seconds) && (s_now > s_early_stop_lim));
        end

        // Duty cycle counter while heating in regulation; wraps at 8 bits.
        cycle_wrap = r_tick ? r_cycle_secs + CW'(1) : r_cycle_secs;

        n_phase      = r_phase;
        n_flag       = r_flag;
        n_on_secs    = r_on_secs;
        n_off_secs   = r_off_secs;
        n_cycle_secs = r_cycle_secs;
        n_warm_secs  = r_warm_secs;
        n_hold_secs  = r_hold_secs;
        n_level      = r_level_hold;

        unique case (r_phase)
            PH_INIT: begin
                n_phase     = PH_WARM;
                n_on_secs   = '0;
                n_off_secs  = '0;
                n_hold_secs = '0;
                n_warm_secs = '0;
                n_level     = oht_pkg::LEVEL_FULL;
            end
            PH_WARM: begin
                if (near_goal) begin
                    n_hold_secs = oht_pkg::HOLD_OFF_SECS;
                    n_flag      = 1'b0;
                    n_phase     = PH_REGUL;
                end else begin
                    n_warm_secs  = warm_inc;
                    n_cycle_secs = (cycle_inc > warm_limit) ? '0 : cycle_inc;
                end
            end
            PH_REGUL: begin
                n_flag  = reg_flag;
                n_level = oht_pkg::LEVEL_OFF;
                if (reg_flag) begin
                    if (cycle_wrap > oht_pkg::DUTY_LOW_SECS) begin
                        n_level = oht_pkg::LEVEL_FULL;
                    end
                    n_cycle_secs = (cycle_wrap > oht_pkg::DUTY_PERIOD_LAST) ? '0 : cycle_wrap;
                end else if (r_off_secs >= oht_pkg::FORCED_RESTART_SECS) begin
                    // Forced restart after a long off period.
                    n_flag = 1'b1;
                end
            end
            default: begin
                n_phase = PH_WARM;
            end
        endcase

        // Hold-off forces the level off and counts down on ticks.
        if (n_hold_secs != '0) begin
            n_level = oht_pkg::LEVEL_OFF;
            if (r_tick) begin
                n_hold_secs = n_hold_secs - HW'(1);
            end
        end

        // On and off time, from the flag after this reading.
        if (n_flag) begin
            if (r_tick && n_on_secs != {CW{1'b1}}) begin
                n_on_secs = n_on_secs + CW'(1);
            end
            n_off_secs = '0;
        end else begin
            if (r_tick && n_off_secs != {CW{1'b1}}) begin
                n_off_secs = n_off_secs + CW'(1);
            end
            n_on_secs = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_temp         <= oht_pkg::RST_GOAL_TEMP;
            r_stop_band_above   <= oht_pkg::RST_STOP_BAND_ABOVE;
            r_start_band_below  <= oht_pkg::RST_START_BAND_BELOW;
            r_early_stop_above  <= oht_pkg::RST_EARLY_STOP_ABOVE;
            r_early_start_above <= oht_pkg::RST_EARLY_START_ABOVE;
            r_min_on_seconds    <= oht_pkg::RST_MIN_ON_SECONDS;
            r_min_off_seconds   <= oht_pkg::RST_MIN_OFF_SECONDS;
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_phase             <= PH_INIT;
            r_flag              <= 1'b0;
            r_on_secs           <= '0;
            r_off_secs          <= '0;
            r_cycle_secs        <= '0;
            r_warm_secs         <= '0;
            r_hold_secs         <= '0;
            r_level_hold        <= oht_pkg::LEVEL_OFF;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    oht_pkg::REG_GOAL_TEMP:         r_goal_temp         <= i_cfg_data;
                    oht_pkg::REG_STOP_BAND_ABOVE:   r_stop_band_above   <= i_cfg_data;
                    oht_pkg::REG_START_BAND_BELOW:  r_start_band_below  <= i_cfg_data;
                    oht_pkg::REG_EARLY_STOP_ABOVE:  r_early_stop_above  <= i_cfg_data;
                    oht_pkg::REG_EARLY_START_ABOVE: r_early_start_above <= i_cfg_data;
                    oht_pkg::REG_MIN_ON_SECONDS:    r_min_on_seconds    <= i_cfg_data;
                    oht_pkg::REG_MIN_OFF_SECONDS:   r_min_off_seconds   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
                r_now_temp <= i_now_temp;
                r_tick     <= i_second_tick;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_phase      <= n_phase;
                r_flag       <= n_flag;
                r_on_secs    <= n_on_secs;
                r_off_secs   <= n_off_secs;
                r_cycle_secs <= n_cycle_secs;
                r_warm_secs  <= n_warm_secs;
                r_hold_secs  <= n_hold_secs;
                r_level_hold <= n_level;
                r_out_valid  <= 1'b1;
                r_out_level  <= n_level;
                r_out_flag   <= n_flag;
                r_out_phase  <= n_phase;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Phases of the controller as they appear on o_phase.
    typedef enum logic [1:0] {
        PH_INIT     = 2'd0,
        PH_WARMUP   = 2'd1,
        PH_REGULATE = 2'd2
    } t_heat_phase;

    // One result transfer, field for field.
    typedef struct packed {
        logic [1:0]  level;
        logic        heating;
        t_heat_phase phase;
    } t_heat_result;

    // A row of the directed plan is either a reading or a register write.
    typedef enum bit {
        ROW_READING   = 1'b0,
        ROW_REG_WRITE = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        oht_pkg::t_reg_index reg_idx;
        logic [7:0]          val;      // reading for a reading row, data for a write row
        bit                  tick;
        bit                  typed;    // the expected result is written out in the row
        t_heat_result        want;
    } t_plan_row;

    // Thermostat constants, kept apart from the design's own package.
    localparam int EXIT_DIFF   = 35;
    localparam int EARLY_SECS  = 120;
    localparam int MID_SECS    = 240;
    localparam int COLD_TEMP   = 80;
    localparam int MID_TEMP    = 100;
    localparam int LIMIT_COLD  = 11;
    localparam int LIMIT_MID   = 16;
    localparam int LIMIT_HOT   = 22;
    localparam int HOLD_SECS   = 10;
    localparam int RESTART_OFF = 60;
    localparam int DUTY_LOW    = 2;
    localparam int DUTY_LAST   = 12;
    localparam int INIT_LEVEL  = 5;
    localparam int BURST_LEVEL = 6;
    localparam int FULL_LEVEL  = 3;

    localparam int ITEMS_TARGET = 1550;
    localparam int SOAK_ITEMS   = 400;
    localparam int STUCK_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;

    localparam t_heat_result NO_WANT = '0;

    // The directed plan. The warm-up rows come first; the long random warm-up
    // soak runs between them and the rows from SOAK_AT onwards, which leave
    // warm-up and exercise the regulation bands.
    localparam int PLAN_LEN = 33;
    localparam int SOAK_AT  = 8;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // Goal at the top so that almost every reading is cold.
        '{ROW_REG_WRITE, oht_pkg::REG_GOAL_TEMP,         8'd255, 1'b0, 1'b0, NO_WANT},
        // Init step: full level, phase moves on to warm-up.
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b0, 1'b1,
          '{2'd3, 1'b0, PH_WARMUP}},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b1,
          '{2'd3, 1'b0, PH_WARMUP}},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd79,  1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd80,  1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd99,  1'b0, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd100, 1'b1, 1'b0, NO_WANT},
        // Exactly 35 counts below the goal still counts as cold.
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd220, 1'b1, 1'b1,
          '{2'd3, 1'b0, PH_WARMUP}},
        // One count closer ends warm-up, and the hold-off forces level 0.
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd221, 1'b1, 1'b1,
          '{2'd0, 1'b0, PH_REGULATE}},
        // Coldest reading: hard start while the hold-off runs out.
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd0,   1'b1, 1'b0, NO_WANT},
        // Zero stop band, and a start band that reaches below zero.
        '{ROW_REG_WRITE, oht_pkg::REG_GOAL_TEMP,         8'd100, 1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_STOP_BAND_ABOVE,   8'd0,   1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_START_BAND_BELOW,  8'd255, 1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_EARLY_STOP_ABOVE,  8'd255, 1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_EARLY_START_ABOVE, 8'd0,   1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_MIN_ON_SECONDS,    8'd0,   1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_MIN_OFF_SECONDS,   8'd255, 1'b0, 1'b0, NO_WANT},
        // Hard stop one count above the goal, then no start at the goal.
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd101, 1'b0, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd100, 1'b1, 1'b0, NO_WANT},
        // Early start once the minimum off time is passed.
        '{ROW_REG_WRITE, oht_pkg::REG_STOP_BAND_ABOVE,   8'd255, 1'b0, 1'b0, NO_WANT},
        '{ROW_REG_WRITE, oht_pkg::REG_MIN_OFF_SECONDS,   8'd0,   1'b0, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd100, 1'b1, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd255, 1'b1, 1'b0, NO_WANT},
        // Early stop once the minimum on time is passed.
        '{ROW_REG_WRITE, oht_pkg::REG_EARLY_STOP_ABOVE,  8'd0,   1'b0, 1'b0, NO_WANT},
        '{ROW_READING,   oht_pkg::REG_GOAL_TEMP,         8'd101, 1'b0, 1'b0, NO_WANT}
    };

    // Ports of the block. Every input has a known value from time zero.
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_now_temp = 8'd0;
    logic       i_second_tick = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_heat_level;
    logic       o_heater_on;
    logic [1:0] o_phase;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    oht_pkg::t_reg_index i_cfg_index = oht_pkg::REG_GOAL_TEMP;
    logic [7:0] i_cfg_data = 8'd0;

    // Our own copy of the controller state and of its registers, at reset.
    t_heat_phase heat_phase = PH_INIT;
    logic        heat_flag = 1'b0;
    logic [7:0]  on_secs = 8'd0;
    logic [7:0]  off_secs = 8'd0;
    logic [7:0]  duty_secs = 8'd0;
    logic [15:0] warm_secs = 16'd0;
    logic [3:0]  hold_secs = 4'd0;
    logic [1:0]  kept_level = 2'd0;
    logic [7:0]  reg_val [7] = '{8'd128, 8'd22, 8'd0, 8'd17, 8'd3, 8'd80, 8'd30};

    t_heat_result expected_heat [$];
    int           items_sent = 0;
    int           mismatches = 0;
    int           stuck_cycles = 0;

    oven_heater_thermostat DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_now_temp    (i_now_temp),
        .i_second_tick (i_second_tick),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_heat_level  (o_heat_level),
        .o_heater_on   (o_heater_on),
        .o_phase       (o_phase),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Works out the result of one reading and advances our copy of the state.
    // All band sums are taken in int, so a band below zero or above 255
    // simply never matches, as in the block's 10-bit signed compares.
    function automatic t_heat_result thermo_step(input logic [7:0] temp, input bit tick);
        int now;
        int goal;
        int lvl;
        int diff;
        int limit;
        int stop_band;
        int start_band;
        int early_stop;
        int early_start;
        t_heat_result res;
        now         = int'(temp);
        goal        = int'(reg_val[oht_pkg::REG_GOAL_TEMP]);
        stop_band   = int'(reg_val[oht_pkg::REG_STOP_BAND_ABOVE]);
        start_band  = int'(reg_val[oht_pkg::REG_START_BAND_BELOW]);
        early_stop  = int'(reg_val[oht_pkg::REG_EARLY_STOP_ABOVE]);
        early_start = int'(reg_val[oht_pkg::REG_EARLY_START_ABOVE]);
        lvl         = int'(kept_level);
        diff        = (goal > now) ? goal - now : 0;
        case (heat_phase)
            PH_INIT: begin
                heat_phase = PH_WARMUP;
                on_secs    = '0;
                off_secs   = '0;
                hold_secs  = '0;
                warm_secs  = '0;
                lvl        = INIT_LEVEL;
            end
            PH_WARMUP: begin
                if (diff < EXIT_DIFF) begin
                    hold_secs  = 4'(HOLD_SECS);
                    heat_flag  = 1'b0;
                    heat_phase = PH_REGULATE;
                end else begin
                    if (tick) begin
                        if (warm_secs != 16'hFFFF) warm_secs++;
                        if (duty_secs != 8'hFF) duty_secs++;
                    end
                    // The duty counter is cut shorter while the oven is still cold.
                    if (warm_secs < EARLY_SECS && now < COLD_TEMP) begin
                        limit = LIMIT_COLD;
                    end else if (warm_secs < MID_SECS && now < MID_TEMP) begin
                        limit = LIMIT_MID;
                    end else begin
                        limit = LIMIT_HOT;
                    end
                    if (duty_secs > limit) duty_secs = '0;
                end
            end
            PH_REGULATE: begin
                lvl = 0;
                if (now > goal + stop_band) begin
                    heat_flag = 1'b0;
                end else if (now <= goal - start_band) begin
                    heat_flag = 1'b1;
                end else if (!heat_flag) begin
                    if (off_secs > reg_val[oht_pkg::REG_MIN_OFF_SECONDS]
                        && now <= goal + early_start)
                        heat_flag = 1'b1;
                end else if (on_secs > reg_val[oht_pkg::REG_MIN_ON_SECONDS]
                             && now > goal + early_stop) begin
                    heat_flag = 1'b0;
                end
                if (heat_flag) begin
                    if (tick) duty_secs++;
                    if (duty_secs > DUTY_LOW) lvl = BURST_LEVEL;
                    if (duty_secs > DUTY_LAST) duty_secs = '0;
                end else if (off_secs >= RESTART_OFF) begin
                    heat_flag = 1'b1;
                end
            end
            default: begin
                heat_phase = PH_WARMUP;
            end
        endcase
        if (lvl > FULL_LEVEL) lvl = FULL_LEVEL;
        if (hold_secs != 0) begin
            if (tick) hold_secs--;
            lvl = 0;
        end
        if (heat_flag) begin
            if (tick && on_secs != 8'hFF) on_secs++;
            off_secs = '0;
        end else begin
            if (tick && off_secs != 8'hFF) off_secs++;
            on_secs = '0;
        end
        kept_level  = lvl[1:0];
        res.level   = lvl[1:0];
        res.heating = heat_flag;
        res.phase   = heat_phase;
        return res;
    endfunction

    // Length of an idle gap or a stall: mostly none or short, now and then long.
    function automatic int pause_len();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 55) return 0;
        if (pick < 88) return int'($urandom_range(1, 3));
        if (pick < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Sends one reading. On entry and on return we stand at a falling edge,
    // and valid is left high so that back-to-back readings need no second
    // assignment in the same time step. Every fourth block of 80 readings is
    // sent without gaps.
    task automatic push_reading(input logic [7:0] temp, input bit tick, input bit typed,
                                input t_heat_result typed_want);
        int gap;
        t_heat_result want;
        gap = ((items_sent / 80) % 4 == 1) ? 0 : pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_now_temp    <= temp;
        i_second_tick <= tick;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = thermo_step(temp, tick);
        expected_heat.push_back(typed ? typed_want : want);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds the reading channel idle until every expected result has come
    // back. It always moves on by at least one falling edge, so the caller
    // never assigns valid twice in one step.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_heat.size() != 0);
    endtask

    // One register write; valid is left high for a following write and the
    // caller lowers it at the falling edge where it returns.
    task automatic write_reg(input oht_pkg::t_reg_index idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_val[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic run_plan(input int first, input int last);
        bit writing;
        writing = 1'b0;
        for (int row = first; row < last; row++) begin
            if (PLAN[row].kind == ROW_REG_WRITE) begin
                if (!writing) wait_drained();
                write_reg(PLAN[row].reg_idx, PLAN[row].val);
                writing = 1'b1;
            end else begin
                if (writing) i_cfg_valid <= 1'b0;
                writing = 1'b0;
                push_reading(PLAN[row].val, PLAN[row].tick, PLAN[row].typed, PLAN[row].want);
            end
        end
    endtask

    // Main sequence: reset, directed plan, warm-up soak, random regulation.
    initial begin : stimulus
        int                  round;
        int                  span;
        int                  oven_temp;
        int                  pick;
        logic [7:0]          reading;
        logic [7:0]          val;
        bit                  tick;
        oht_pkg::t_reg_index idx;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_plan(0, SOAK_AT);

        // Warm-up soak: the goal sits at 255, so every reading up to 220 stays
        // cold. Enough ticks pass to cross both the two-minute and the
        // four-minute marks of the warm-up timer with readings on both sides
        // of the cold and middle temperatures.
        repeat (SOAK_ITEMS) begin
            push_reading(8'($urandom_range(0, 220)), $urandom_range(0, 6) != 0, 1'b0, NO_WANT);
        end

        run_plan(SOAK_AT, PLAN_LEN);

        // Random regulation in rounds. Each round starts with the block idle,
        // writes all seven registers (all zero in the first round, all 255 in
        // the second, then a mix of extremes and usual values) and then feeds
        // a simulated oven whose temperature climbs while the heater is on and
        // sinks while it is off, so that the on and off times grow long enough
        // for the early bands and the forced restart. One reading in twelve
        // is replaced by noise across the whole range.
        round = 0;
        while (items_sent < ITEMS_TARGET) begin
            wait_drained();
            for (int r = 0; r < 7; r++) begin
                idx  = oht_pkg::t_reg_index'(r);
                pick = int'($urandom_range(0, 9));
                if (round == 0 || (round > 1 && pick == 0)) begin
                    val = 8'd0;
                end else if (round == 1 || pick == 1) begin
                    val = 8'd255;
                end else if (idx == oht_pkg::REG_GOAL_TEMP) begin
                    val = 8'($urandom_range(40, 215));
                end else if (idx == oht_pkg::REG_MIN_ON_SECONDS
                             || idx == oht_pkg::REG_MIN_OFF_SECONDS) begin
                    val = 8'($urandom_range(0, 90));
                end else begin
                    val = 8'($urandom_range(0, 40));
                end
                write_reg(idx, val);
            end
            i_cfg_valid <= 1'b0;

            oven_temp = int'(reg_val[oht_pkg::REG_GOAL_TEMP])
                        + int'($urandom_range(0, 60)) - 30;
            span      = int'($urandom_range(80, 160));
            repeat (span) begin
                if (oven_temp < 0) oven_temp = 0;
                if (oven_temp > 255) oven_temp = 255;
                // Now and then the sender waits for every result to come back.
                if ($urandom_range(0, 149) == 0) wait_drained();
                tick    = $urandom_range(0, 3) != 0;
                reading = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'(oven_temp);
                push_reading(reading, tick, 1'b0, NO_WANT);
                if (tick) begin
                    if (heat_flag) oven_temp += int'($urandom_range(0, 2));
                    else oven_temp -= int'($urandom_range(0, 2));
                end
            end
            round++;
        end

        // A result still owed here shows up as a watchdog timeout.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS oven_heater_thermostat");
        end else begin
            $display("FAIL oven_heater_thermostat");
        end
        $finish;
    end

    // Result side: stalls of random length, with quiet stretches in which no
    // new stall starts and it takes each transfer once a running stall ends.
    initial begin : result_sink
        int stall_left;
        int cycle_no;
        stall_left = 0;
        cycle_no   = 0;
        forever begin
            @(negedge i_clk);
            cycle_no++;
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if ((cycle_no / 256) % 4 != 2 && $urandom_range(0, 3) == 0)
                    stall_left = pause_len();
            end
        end
    end

    // Every result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_heat_result got;
        t_heat_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.level   = o_heat_level;
            got.heating = o_heater_on;
            got.phase   = t_heat_phase'(o_phase);
            if (expected_heat.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: level %0d heater %0d phase %0d",
                             got.level, got.heating, got.phase);
            end else begin
                want = expected_heat.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch: level %0d/%0d heater %0d/%0d phase %0d/%0d %s",
                                 want.level, got.level, want.heating, got.heating,
                                 want.phase, got.phase, "(expected/actual)");
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any transfer ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL oven_heater_thermostat");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

// ===== oven_heater_thermostat.f =====
rtl/oht_pkg.sv
rtl/oven_heater_thermostat.sv
tb/sv/tb.sv
